### sv/csdd_pkg.sv
// Package for the charlieplexed seven-segment display driver.
// Holds the command codes, segment placement tables and buffer update functions.
// No dependencies.
package csdd_pkg;

   localparam int PIN_COUNT   = 7;
   localparam int DIGIT_COUNT = 4;
   localparam int SEG_COUNT   = 7;
   localparam int GLYPH_COUNT = 19;
   localparam int DOT_COUNT   = 7;
   localparam int GROUP_COUNT = 3;
   localparam int ROW_W       = $clog2(PIN_COUNT);
   localparam int POS_W       = $clog2(DIGIT_COUNT);
   localparam int CODE_W      = 5;
   localparam int DOT_W       = 3;
   localparam int VOL_W       = 7;
   localparam int FUNC_W      = 3;

   localparam logic [CODE_W-1:0] GLYPH_U     = CODE_W'(16);
   localparam logic [CODE_W-1:0] GLYPH_BLANK = CODE_W'(17);
   localparam logic [VOL_W-1:0]  VOL_MAX     = VOL_W'(99);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_GLYPH  = 3'd0,
      FUNC_DOT    = 3'd1,
      FUNC_GROUP  = 3'd2,
      FUNC_SCAN   = 3'd3,
      FUNC_VOLUME = 3'd4
   } func_type;

   typedef logic [PIN_COUNT-1:0] row_type;
   typedef row_type [PIN_COUNT-1:0] seg_buf_type;

   // Placement byte: upper nibble is the buffer row, lower nibble the pin bit.
   localparam logic [7:0] SEG_PLACE [DIGIT_COUNT][SEG_COUNT] = '{
      '{8'h01, 8'h02, 8'h30, 8'h40, 8'h03, 8'h10, 8'h20},
      '{8'h12, 8'h13, 8'h41, 8'h15, 8'h14, 8'h21, 8'h31},
      '{8'h43, 8'h24, 8'h34, 8'h50, 8'h52, 8'h32, 8'h42},
      '{8'h65, 8'h56, 8'h45, 8'h53, 8'h35, 8'h54, 8'h46}
   };

   localparam logic [SEG_COUNT-1:0] GLYPH_BITS [GLYPH_COUNT] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7C, 7'h27, 7'h7F, 7'h67,
      7'h77, 7'h7D, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3E, 7'h00, 7'h40
   };

   localparam logic [7:0] DOT_PLACE [DOT_COUNT] = '{
      8'h05, 8'h25, 8'h51, 8'h04, 8'h23, 8'h62, 8'h64
   };

   localparam logic [7:0] GROUP_PLACE [GROUP_COUNT] = '{8'h06, 8'h16, 8'h36};

   function automatic seg_buf_type put_segment(seg_buf_type b, logic [7:0] place,
                                               logic lit);
      seg_buf_type r;
      r = b;
      if (place[7:4] < 4'(PIN_COUNT) && place[3:0] < 4'(PIN_COUNT)) begin
         r[place[ROW_W-1+4:4]][place[ROW_W-1:0]] = lit;
      end
      return r;
   endfunction

   function automatic seg_buf_type write_glyph(seg_buf_type b, logic [POS_W-1:0] pos,
                                               logic [CODE_W-1:0] code);
      seg_buf_type          r;
      logic [SEG_COUNT-1:0] pattern;
      r       = b;
      pattern = (code < CODE_W'(GLYPH_COUNT)) ? GLYPH_BITS[code] : '0;
      for (int i = 0; i < SEG_COUNT; i++) begin
         r = put_segment(r, SEG_PLACE[pos][i], pattern[i]);
      end
      return r;
   endfunction

   // Tens digit by reciprocal multiply, exact for values up to 99.
   function automatic logic [CODE_W-1:0] vol_tens(logic [VOL_W-1:0] v);
      logic [14:0] prod;
      prod = 15'(v) * 15'd205;
      return CODE_W'(prod >> 11);
   endfunction

   function automatic logic [CODE_W-1:0] vol_ones(logic [VOL_W-1:0] v,
                                                  logic [CODE_W-1:0] tens);
      logic [VOL_W-1:0] t10;
      t10 = VOL_W'(tens) * VOL_W'(10);
      return CODE_W'(v - t10);
   endfunction

endpackage

### sv/csdd_req_if.sv
// Command channel interface of the display driver.
// Depends on csdd_pkg for field widths.
interface csdd_req_if;
   import csdd_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [POS_W-1:0]    digit_pos;
   logic [CODE_W-1:0]   glyph_code;
   logic [DOT_W-1:0]    dot_index;
   logic                light_on;
   logic [VOL_W-1:0]    volume_value;

   modport source (output valid, func, digit_pos, glyph_code, dot_index, light_on,
                   volume_value, input ready);
   modport sink (input valid, func, digit_pos, glyph_code, dot_index, light_on,
                 volume_value, output ready);
endinterface

### sv/csdd_rsp_if.sv
// Scan result channel interface of the display driver.
// Depends on csdd_pkg for field widths.
interface csdd_rsp_if;
   import csdd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ROW_W-1:0]     active_row;
   logic [PIN_COUNT-1:0] drive_high_mask;
   logic [PIN_COUNT-1:0] drive_low_mask;

   modport source (output valid, active_row, drive_high_mask, drive_low_mask,
                   input ready);
   modport sink (input valid, active_row, drive_high_mask, drive_low_mask,
                 output ready);
endinterface

### sv/charlieplex_segment_display_driver.sv
// Top level of the charlieplexed seven-segment display driver.
// Depends on csdd_pkg, csdd_req_if and csdd_rsp_if.
//
// Usage:
//   req_bus carries commands: glyph write to a digit, dot set/clear, K7 group
//   set/clear, scan tick and volume display. A beat is taken when valid and
//   ready are both high. Only a scan tick produces a beat on rsp_bus: the
//   active row pin, its one-hot high-drive mask and the low-drive mask from the
//   segment buffer row (active pin's own bit cleared). Other pins float.
//   Commands land in an input register, then the execute logic updates the
//   segment buffer and, for a scan tick, loads the result register.
//   A scan tick reaches rsp_bus through the input and then the result register.
//   Throughput: one command per cycle, set by the single execute stage,
//   but a stalled receiver holds the result register; further commands still
//   execute until a scan tick reaches the input register, which then holds
//   the tick and drops req_bus.ready until the result beat is taken.
//   Reset (synchronous, active high) clears the segment buffer, the scan row
//   and both valid flags.
module charlieplex_segment_display_driver (
   input logic       clock,
   input logic       reset,
   csdd_req_if.sink   req_bus,
   csdd_rsp_if.source rsp_bus
);
   import csdd_pkg::*;

   logic                 item_vld_ff;
   logic [FUNC_W-1:0]    func_ff;
   logic [POS_W-1:0]     pos_ff;
   logic [CODE_W-1:0]    code_ff;
   logic [DOT_W-1:0]     dot_ff;
   logic                 on_ff;
   logic [VOL_W-1:0]     vol_ff;

   seg_buf_type          seg_buf_ff;
   seg_buf_type          seg_buf_in;
   logic [ROW_W-1:0]     scan_row_ff;
   logic [ROW_W-1:0]     scan_row_in;

   logic                 rsp_vld_ff;
   logic [ROW_W-1:0]     row_out_ff;
   logic [PIN_COUNT-1:0] high_out_ff;
   logic [PIN_COUNT-1:0] low_out_ff;

   logic                 is_scan;
   logic                 item_go;
   logic                 req_take;
   logic [VOL_W-1:0]     vol_sat;
   logic [CODE_W-1:0]    tens;
   logic [CODE_W-1:0]    ones;
   logic [PIN_COUNT-1:0] high_mask;

   assign is_scan  = (func_type'(func_ff) == FUNC_SCAN);
   assign item_go  = item_vld_ff && (!is_scan || !rsp_vld_ff || rsp_bus.ready);
   assign req_take = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !item_vld_ff || item_go;

   assign vol_sat   = (vol_ff > VOL_MAX) ? VOL_MAX : vol_ff;
   assign tens      = vol_tens(vol_sat);
   assign ones      = vol_ones(vol_sat, tens);
   assign high_mask = PIN_COUNT'(1) << scan_row_ff;

   always_comb begin
      seg_buf_in  = seg_buf_ff;
      scan_row_in = scan_row_ff;
      case (func_type'(func_ff))
         FUNC_GLYPH: begin
            seg_buf_in = write_glyph(seg_buf_ff, pos_ff, code_ff);
         end
         FUNC_DOT: begin
            if (dot_ff < DOT_W'(DOT_COUNT)) begin
               seg_buf_in = put_segment(seg_buf_ff, DOT_PLACE[dot_ff], on_ff);
            end
         end
         FUNC_GROUP: begin
            for (int i = 0; i < GROUP_COUNT; i++) begin
               seg_buf_in = put_segment(seg_buf_in, GROUP_PLACE[i], on_ff);
            end
         end
         FUNC_SCAN: begin
            scan_row_in = (scan_row_ff == ROW_W'(PIN_COUNT - 1)) ? '0
                                                                 : scan_row_ff + 1'b1;
         end
         FUNC_VOLUME: begin
            seg_buf_in = write_glyph(seg_buf_in, POS_W'(0), GLYPH_BLANK);
            seg_buf_in = write_glyph(seg_buf_in, POS_W'(1), GLYPH_U);
            seg_buf_in = write_glyph(seg_buf_in, POS_W'(2), tens);
            seg_buf_in = write_glyph(seg_buf_in, POS_W'(3), ones);
         end
         default: begin
            seg_buf_in = seg_buf_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else if (req_bus.ready) begin
         item_vld_ff <= req_bus.valid;
      end
      if (req_take) begin
         func_ff <= req_bus.func;
         pos_ff  <= req_bus.digit_pos;
         code_ff <= req_bus.glyph_code;
         dot_ff  <= req_bus.dot_index;
         on_ff   <= req_bus.light_on;
         vol_ff  <= req_bus.volume_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_buf_ff  <= '0;
         scan_row_ff <= '0;
      end else if (item_go) begin
         seg_buf_ff  <= seg_buf_in;
         scan_row_ff <= scan_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (item_go && is_scan) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (item_go && is_scan) begin
         row_out_ff  <= scan_row_ff;
         high_out_ff <= high_mask;
         low_out_ff  <= seg_buf_ff[scan_row_ff] & ~high_mask;
      end
   end

   assign rsp_bus.valid           = rsp_vld_ff;
   assign rsp_bus.active_row      = row_out_ff;
   assign rsp_bus.drive_high_mask = high_out_ff;
   assign rsp_bus.drive_low_mask  = low_out_ff;

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      scan_row_ff < ROW_W'(PIN_COUNT))
      else $error("scan row out of range");

   a_high_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> $onehot(high_out_ff))
      else $error("high-drive mask not one-hot");

   a_no_short: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> ((high_out_ff & low_out_ff) == '0))
      else $error("pin driven high and low");

   a_row_step: assert property (@(posedge clock) disable iff (reset)
      (item_go && is_scan) |=>
         (scan_row_ff == (($past(scan_row_ff) == ROW_W'(PIN_COUNT - 1)) ? '0
                          : $past(scan_row_ff) + 1'b1)))
      else $error("scan row did not advance");

   a_row_out: assert property (@(posedge clock) disable iff (reset)
      (item_go && is_scan) |=> (row_out_ff == $past(scan_row_ff)))
      else $error("reported row mismatch");

endmodule
